[hdl/btlv_pkg.sv]
// shared types and codes for the ber-tlv header parser
// used by btlv_decode and ber_tlv_header_parser_core; no dependencies
package btlv_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_TAG1  = 3'd0,
      PH_TAG2  = 3'd1,
      PH_LEN1  = 3'd2,
      PH_LENX  = 3'd3,
      PH_VALUE = 3'd4
   } phase_type;

   // byte roles
   localparam logic [1:0] ROLE_TAG   = 2'd0;
   localparam logic [1:0] ROLE_LEN   = 2'd1;
   localparam logic [1:0] ROLE_VALUE = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_HDR_TRUNC  = 3'd1;
   localparam logic [2:0] ERR_BAD_TAG2   = 3'd2;
   localparam logic [2:0] ERR_LEN_FORM   = 3'd3;
   localparam logic [2:0] ERR_VAL_TRUNC  = 3'd4;

   // header byte codes
   localparam logic [4:0] TAG_MULTI_MASK = 5'h1f;
   localparam logic [7:0] LEN_LONG_ONE   = 8'h81;
   localparam logic [7:0] LEN_LONG_TWO   = 8'h82;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  byte_role;
      logic [7:0]  byte_out;
      logic [15:0] tag_value;
      logic [15:0] value_length;
      logic        tlv_done;
      logic [16:0] total_length;
      logic [2:0]  error_code;
   } rsp_item_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] tag_reg;
      logic [15:0] length_reg;
      logic [1:0]  octets_left;
      logic [15:0] value_remaining;
      logic [16:0] consumed_count;
   } parse_state_type;

endpackage

[hdl/btlv_decode.sv]
// per-byte parse step: next parser state and the result for one byte
// combinational only; depends on btlv_pkg
module btlv_decode (
   input  btlv_pkg::parse_state_type cur_state,
   input  btlv_pkg::req_item_type    item,
   output btlv_pkg::parse_state_type nxt_state,
   output btlv_pkg::rsp_item_type    result
);
   import btlv_pkg::*;

   logic [7:0]  b;
   logic        at_end;
   logic [16:0] cnt;
   logic [1:0]  role;
   logic [15:0] tag_nxt;
   logic [15:0] len_nxt;
   logic [1:0]  oct_nxt;
   logic [15:0] rem_nxt;
   logic [15:0] vlen;
   logic        header_done;
   logic        header_go;
   logic        done;
   logic [2:0]  err;
   logic        restart;
   phase_type   phase_nxt;

   assign b      = item.data_byte;
   assign at_end = item.buffer_end;
   assign cnt    = cur_state.consumed_count + 17'd1;

   // datapath and flags
   always_comb begin
      role        = ROLE_TAG;
      tag_nxt     = cur_state.tag_reg;
      len_nxt     = cur_state.length_reg;
      oct_nxt     = cur_state.octets_left;
      rem_nxt     = cur_state.value_remaining;
      vlen        = 16'd0;
      header_done = 1'b0;
      done        = 1'b0;
      err         = ERR_NONE;
      unique case (cur_state.phase)
         PH_TAG2: begin
            tag_nxt = {cur_state.tag_reg[7:0], b};
            if (b[7]) begin
               err = ERR_BAD_TAG2;
            end else if (at_end) begin
               err = ERR_HDR_TRUNC;
            end
         end
         PH_LEN1: begin
            role = ROLE_LEN;
            if (!b[7]) begin
               len_nxt     = {8'd0, b};
               header_done = 1'b1;
            end else if (b == LEN_LONG_ONE || b == LEN_LONG_TWO) begin
               oct_nxt = b[1:0];
               len_nxt = 16'd0;
               if (at_end) begin
                  err = ERR_HDR_TRUNC;
               end
            end else begin
               err = ERR_LEN_FORM;
            end
         end
         PH_LENX: begin
            role    = ROLE_LEN;
            len_nxt = {cur_state.length_reg[7:0], b};
            if (cur_state.octets_left <= 2'd1) begin
               oct_nxt     = 2'd0;
               header_done = 1'b1;
            end else begin
               oct_nxt = cur_state.octets_left - 2'd1;
               if (at_end) begin
                  err = ERR_HDR_TRUNC;
               end
            end
         end
         PH_VALUE: begin
            role = ROLE_VALUE;
            vlen = cur_state.length_reg;
            if (cur_state.value_remaining <= 16'd1) begin
               rem_nxt = 16'd0;
               done    = 1'b1;
            end else begin
               rem_nxt = cur_state.value_remaining - 16'd1;
               if (at_end) begin
                  err = ERR_VAL_TRUNC;
               end
            end
         end
         default: begin
            // first tag byte; unused phase codes behave the same
            tag_nxt = {8'd0, b};
            if (at_end) begin
               err = ERR_HDR_TRUNC;
            end
         end
      endcase

      if (header_done) begin
         vlen = len_nxt;
         if (len_nxt == 16'd0) begin
            done = 1'b1;
         end else begin
            rem_nxt = len_nxt;
            if (at_end) begin
               err = ERR_VAL_TRUNC;
            end
         end
      end
   end

   assign header_go = header_done && (len_nxt != 16'd0);
   assign restart   = done || (err != ERR_NONE) || at_end;

   // next phase
   always_comb begin
      unique case (cur_state.phase)
         PH_TAG2:  phase_nxt = b[7] ? PH_TAG1 : PH_LEN1;
         PH_LEN1:  phase_nxt = (b == LEN_LONG_ONE || b == LEN_LONG_TWO) ? PH_LENX : PH_TAG1;
         PH_LENX:  phase_nxt = PH_LENX;
         PH_VALUE: phase_nxt = PH_VALUE;
         default:  phase_nxt = (b[4:0] == TAG_MULTI_MASK) ? PH_TAG2 : PH_LEN1;
      endcase
      if (header_go) begin
         phase_nxt = PH_VALUE;
      end
      if (restart) begin
         phase_nxt = PH_TAG1;
      end
   end

   // state and result outputs
   always_comb begin
      if (restart) begin
         nxt_state = '0;
         nxt_state.phase = PH_TAG1;
      end else begin
         nxt_state.phase           = phase_nxt;
         nxt_state.tag_reg         = tag_nxt;
         nxt_state.length_reg      = len_nxt;
         nxt_state.octets_left     = oct_nxt;
         nxt_state.value_remaining = rem_nxt;
         nxt_state.consumed_count  = cnt;
      end
      result.byte_role    = role;
      result.byte_out     = b;
      result.tag_value    = tag_nxt;
      result.value_length = vlen;
      result.tlv_done     = done;
      result.total_length = done ? cnt : 17'd0;
      result.error_code   = err;
   end

endmodule

[hdl/ber_tlv_header_parser_core.sv]
// ber-tlv header parser top level: input register, parse step, result register
// depends on btlv_pkg and btlv_decode
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | req_item  (data byte, buffer end)
//   rsp     | out       | rsp_valid/stall  | rsp_item  (role, byte, tag, lengths, error)
//
// one byte per cycle sustained while rsp is not stalled; rsp valid once the byte has passed both registers
// the rate is set by the parser state update between the registers
// reset (synchronous, active high) empties both registers and returns the parser to tag
// a stall on rsp holds the result register; req stalls only when both registers are full
module ber_tlv_header_parser_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  btlv_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output btlv_pkg::rsp_item_type rsp_item
);
   import btlv_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_item_type    in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_item_type    out_item_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_item_type    step_result;
   logic            advance;
   logic            step_go;

   // result register free or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   btlv_decode u_decode (
      .cur_state (state_ff),
      .item      (in_item_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         // all-zero state has phase PH_TAG1
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
      if (step_go) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

[tb/tb.sv]
// self-checking testbench for ber_tlv_header_parser_core: a per-byte label predictor,
// a queue-fed driver, and a monitor that checks every result transfer in order
// depends on btlv_pkg and the ber_tlv_header_parser_core rtl
`timescale 1ns / 1ps

module tb;
   import btlv_pkg::*;

   localparam int STREAM_BYTES = 1050;
   localparam int TAIL_BYTES   = 120;
   localparam int HOLD_CYCLES  = 60;
   localparam int HOLD_AFTER   = 300;
   localparam int WATCHDOG     = 2000;
   localparam int MAX_REPORTS  = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   ber_tlv_header_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_item_type byte_stream[$];
   rsp_item_type expected_labels[$];

   int unsigned bytes_sent     = 0;
   int unsigned bytes_labeled  = 0;
   int unsigned tlvs_completed = 0;
   int unsigned error_labels   = 0;
   int unsigned fail_count     = 0;
   int unsigned send_gap       = 0;
   int unsigned recv_gap       = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;
   int unsigned quiet_cycles   = 0;

   // parser state mirrored by the predictor
   phase_type   prs_phase;
   logic [15:0] prs_tag;
   logic [15:0] prs_len;
   logic [1:0]  prs_octets;
   logic [15:0] prs_remaining;
   logic [16:0] prs_count;

   function automatic void parser_restart();
      prs_phase     = PH_TAG1;
      prs_tag       = '0;
      prs_len       = '0;
      prs_octets    = '0;
      prs_remaining = '0;
      prs_count     = '0;
   endfunction

   function automatic rsp_item_type label_byte(input req_item_type it);
      logic [7:0]   b;
      logic         last;
      logic [1:0]   role;
      logic [15:0]  vlen;
      logic [2:0]   err;
      logic         done;
      logic         hdr_done;
      logic [16:0]  cnt;
      rsp_item_type r;
      b        = it.data_byte;
      last     = it.buffer_end;
      role     = ROLE_TAG;
      vlen     = '0;
      err      = ERR_NONE;
      done     = 1'b0;
      hdr_done = 1'b0;
      cnt      = prs_count + 17'd1;
      case (prs_phase)
         PH_TAG2: begin
            role    = ROLE_TAG;
            prs_tag = {prs_tag[7:0], b};
            if (b[7]) begin
               err = ERR_BAD_TAG2;
            end else begin
               prs_phase = PH_LEN1;
               if (last) err = ERR_HDR_TRUNC;
            end
         end
         PH_LEN1: begin
            role = ROLE_LEN;
            if (!b[7]) begin
               prs_len  = {8'd0, b};
               hdr_done = 1'b1;
            end else if (b == LEN_LONG_ONE || b == LEN_LONG_TWO) begin
               prs_octets = b[1:0];
               prs_len    = '0;
               prs_phase  = PH_LENX;
               if (last) err = ERR_HDR_TRUNC;
            end else begin
               err = ERR_LEN_FORM;
            end
         end
         PH_LENX: begin
            role    = ROLE_LEN;
            prs_len = {prs_len[7:0], b};
            if (prs_octets <= 2'd1) begin
               prs_octets = '0;
               hdr_done   = 1'b1;
            end else begin
               prs_octets = prs_octets - 2'd1;
               if (last) err = ERR_HDR_TRUNC;
            end
         end
         PH_VALUE: begin
            role = ROLE_VALUE;
            vlen = prs_len;
            if (prs_remaining <= 16'd1) begin
               prs_remaining = '0;
               done          = 1'b1;
            end else begin
               prs_remaining = prs_remaining - 16'd1;
               if (last) err = ERR_VAL_TRUNC;
            end
         end
         default: begin
            role      = ROLE_TAG;
            prs_tag   = {8'd0, b};
            prs_phase = (b[4:0] == TAG_MULTI_MASK) ? PH_TAG2 : PH_LEN1;
            if (last) err = ERR_HDR_TRUNC;
         end
      endcase
      if (hdr_done) begin
         vlen = prs_len;
         if (prs_len == 16'd0) begin
            done = 1'b1;
         end else begin
            prs_phase     = PH_VALUE;
            prs_remaining = prs_len;
            if (last) err = ERR_VAL_TRUNC;
         end
      end
      r.byte_role    = role;
      r.byte_out     = b;
      r.tag_value    = prs_tag;
      r.value_length = vlen;
      r.tlv_done     = done;
      r.total_length = done ? cnt : 17'd0;
      r.error_code   = err;
      prs_count = cnt;
      if (done || err != ERR_NONE || last) parser_restart();
      return r;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic last);
      req_item_type it;
      it.data_byte  = b;
      it.buffer_end = last;
      byte_stream.push_back(it);
   endtask

   // one random tlv: mostly well formed, some cut short by a buffer end,
   // some with a broken header, and a little noise
   task automatic queue_random_tlv();
      logic [7:0]  hdr[$];
      logic [7:0]  first;
      logic [7:0]  second;
      int unsigned kind;
      int unsigned pick;
      int unsigned len;
      int unsigned count;
      int unsigned i;
      bit          bad_tag;
      bit          bad_len;
      bit          end_on_last;
      kind = $urandom_range(0, 99);
      if (kind >= 92) begin
         // noise, closed by a buffer end so the parser starts clean again
         count = $urandom_range(1, 6);
         for (i = 0; i < count; i++)
            queue_byte(8'($urandom), (i == count - 1) || ($urandom_range(0, 7) == 0));
         return;
      end
      bad_tag = (kind >= 85 && kind < 88);
      bad_len = (kind >= 88 && kind < 92);
      first   = 8'($urandom);
      if (bad_tag || $urandom_range(0, 2) == 0) begin
         first[4:0] = TAG_MULTI_MASK;
         second     = 8'($urandom);
         second[7]  = bad_tag;
         hdr.push_back(first);
         hdr.push_back(second);
      end else begin
         if (first[4:0] == TAG_MULTI_MASK) first[0] = 1'b0;
         hdr.push_back(first);
      end
      if (bad_len)
         hdr.push_back(($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom_range(8'h83, 8'hff)));
      if (bad_tag || bad_len) begin
         end_on_last = ($urandom_range(0, 3) == 0);
         for (i = 0; i < hdr.size(); i++)
            queue_byte(hdr[i], end_on_last && (i == hdr.size() - 1));
         return;
      end
      if (kind >= 70) begin
         // large random length, cut somewhere in the header or the value
         len = $urandom_range(0, 65535);
         if (len < 256 && $urandom_range(0, 1) == 0) begin
            hdr.push_back(LEN_LONG_ONE);
         end else begin
            hdr.push_back(LEN_LONG_TWO);
            hdr.push_back(8'(len >> 8));
         end
         hdr.push_back(8'(len));
         count       = $urandom_range(1, hdr.size() + ((len < 24) ? len : 24));
         end_on_last = 1'b1;
      end else begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            len = (pick == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            hdr.push_back(8'(len));
         end else if (pick < 16) begin
            len = (pick == 15) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            hdr.push_back(LEN_LONG_ONE);
            hdr.push_back(8'(len));
         end else begin
            len = (pick == 19) ? $urandom_range(0, 300) : $urandom_range(0, 40);
            hdr.push_back(LEN_LONG_TWO);
            hdr.push_back(8'(len >> 8));
            hdr.push_back(8'(len));
         end
         count       = hdr.size() + len;
         end_on_last = ($urandom_range(0, 9) == 0);
      end
      for (i = 0; i < count; i++)
         queue_byte((i < hdr.size()) ? hdr[i] : 8'($urandom), end_on_last && (i == count - 1));
   endtask

   // driver: offers queued bytes, holds a stalled transfer, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_item  <= '0;
         send_gap  = 0;
         parser_restart();
      end else begin
         if (req_valid && !req_stall) begin
            expected_labels.push_back(label_byte(req_item));
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_stream.size() == 0) begin
               req_valid <= 1'b0;
            end else if (byte_stream.size() > TAIL_BYTES && hold_left == 0
                         && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 7) - 1;
               req_valid <= 1'b0;
            end else begin
               req_item  <= byte_stream.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor: checks each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            bytes_labeled++;
            if (rsp_item.tlv_done) tlvs_completed++;
            if (rsp_item.error_code != ERR_NONE) error_labels++;
            if (expected_labels.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("ERROR: result transfer with nothing expected: %p", rsp_item);
            end else begin
               want = expected_labels.pop_front();
               if (rsp_item.byte_role !== want.byte_role
                   || rsp_item.byte_out !== want.byte_out
                   || rsp_item.tag_value !== want.tag_value
                   || rsp_item.value_length !== want.value_length
                   || rsp_item.tlv_done !== want.tlv_done
                   || rsp_item.total_length !== want.total_length
                   || rsp_item.error_code !== want.error_code) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("ERROR: result %0d mismatch", bytes_labeled);
                     $display("  expected role %0d byte %h tag %h vlen %0d done %0d total %0d err %0d",
                              want.byte_role, want.byte_out, want.tag_value, want.value_length,
                              want.tlv_done, want.total_length, want.error_code);
                     $display("  actual   role %0d byte %h tag %h vlen %0d done %0d total %0d err %0d",
                              rsp_item.byte_role, rsp_item.byte_out, rsp_item.tag_value,
                              rsp_item.value_length, rsp_item.tlv_done, rsp_item.total_length,
                              rsp_item.error_code);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && bytes_sent >= HOLD_AFTER) begin
            // long hold-off so both pipeline registers fill and req stalls
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (byte_stream.size() > TAIL_BYTES && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 7) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("ERROR: no transfer for %0d cycles, %0d predictions outstanding",
                     WATCHDOG, expected_labels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      // zero length, two-byte tag with 0x7f second byte and one value byte
      queue_byte(8'h5a, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(8'h9f, 1'b0); queue_byte(8'h7f, 1'b0);
      queue_byte(8'h01, 1'b0); queue_byte(8'haa, 1'b0);
      // bad second tag byte, then length 0x80
      queue_byte(8'hff, 1'b0); queue_byte(8'h85, 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'h80, 1'b0);
      // non-minimal long forms: 0x81 0x01 with a value, 0x82 0x00 0x00 empty
      queue_byte(8'h30, 1'b0); queue_byte(8'h81, 1'b0);
      queue_byte(8'h01, 1'b0); queue_byte(8'h55, 1'b0);
      queue_byte(8'h40, 1'b0); queue_byte(8'h82, 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
      // buffer end inside the header: first tag, second tag, length octets
      queue_byte(8'h70, 1'b1);
      queue_byte(8'h3f, 1'b0); queue_byte(8'h00, 1'b1);
      queue_byte(8'h30, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'h12, 1'b1);
      // buffer end inside the value
      queue_byte(8'h30, 1'b0); queue_byte(8'h02, 1'b0); queue_byte(8'h11, 1'b1);
      // header errors that also carry the buffer end
      queue_byte(8'h1f, 1'b0); queue_byte(8'hc0, 1'b1);
      queue_byte(8'h30, 1'b0); queue_byte(8'hff, 1'b1);
      while (byte_stream.size() < STREAM_BYTES) queue_random_tlv();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (byte_stream.size() != 0 || req_valid || expected_labels.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      $display("run covered %0d bytes in, %0d labels out: %0d complete tlvs, %0d error labels",
               bytes_sent, bytes_labeled, tlvs_completed, error_labels);
      $display("random idling on both sides plus one %0d-cycle receiver hold-off; %0d failures",
               HOLD_CYCLES, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
